// File: rtl/core/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define PSG_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define PSG_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/psg_pkg.sv
package psg_pkg;

    // fixed field widths
    localparam int LIMIT_W     = 13;
    localparam int INDEX_W     = 13;
    localparam int PRIME_OUT_W = 32;
    localparam int LIMIT_RESET = 4096;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_EMIT,
        ST_FETCH,
        ST_LOAD,
        ST_DIV,
        ST_EVAL,
        ST_COMMIT,
        ST_DONE
    } psg_state_t;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic clr_idx;
        logic inc_idx;
        logic rd_emit;
        logic rd_div;
        logic div_load;
        logic div_step;
        logic advance;
        logic commit;
        logic emit_table;
        logic emit_done;
    } psg_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic at_limit;
        logic need_new;
        logic stop;
        logic idx_end;
        logic div_last;
        logic p_gt_q;
        logic rem_zero;
        logic out_free;
    } psg_status_t;

endpackage

// File: rtl/core/psg_datapath.sv
module psg_datapath
    import psg_pkg::*;
#(
    parameter int TABLE_DEPTH = 4096,
    parameter int PRIME_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [LIMIT_W-1:0]     cfg_wr_data,
    input  logic                   restart,
    input  psg_cmd_t               cmd,
    output psg_status_t            status,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [PRIME_OUT_W-1:0] prime,
    output logic [INDEX_W-1:0]     prime_index,
    output logic                   done_res
);

    localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int DCNT_W = $clog2(PRIME_WIDTH + 1);
    localparam int CMP_W  = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int EXT_W  = (PRIME_WIDTH > PRIME_OUT_W) ? PRIME_WIDTH : PRIME_OUT_W;
    localparam int IEXT_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    // sequence state
    logic [LIMIT_W-1:0]     limit_reg;
    logic [CNT_W-1:0]       found_reg;
    logic [CNT_W-1:0]       emitted_reg;
    logic [CNT_W-1:0]       idx_reg;
    logic [PRIME_WIDTH-1:0] cand_reg;
    logic                   phase_reg;
    logic                   ovf_reg;

    // table read side
    logic [PRIME_WIDTH-1:0] mem [TABLE_DEPTH];
    logic [PRIME_WIDTH-1:0] rd_data_reg;
    logic                   rd_two_reg;
    logic                   rd_three_reg;
    logic [CNT_W-1:0]       rd_addr_full;
    logic                   rd_en;
    logic [PRIME_WIDTH-1:0] p_val;

    // divider
    logic [PRIME_WIDTH-1:0] dvs_reg;
    logic [PRIME_WIDTH-1:0] quo_reg;
    logic [PRIME_WIDTH-1:0] rem_reg;
    logic [DCNT_W-1:0]      dcnt_reg;
    logic [PRIME_WIDTH:0]   trial;
    logic [PRIME_WIDTH:0]   diff;
    logic                   trial_ge;

    // result register
    logic                   out_valid_reg;
    logic [PRIME_OUT_W-1:0] prime_reg;
    logic [INDEX_W-1:0]     index_reg;
    logic                   done_reg;

    logic [PRIME_WIDTH:0]   cand_sum;
    logic [EXT_W-1:0]       cand_ext;
    logic [EXT_W-1:0]       p_ext;
    logic [IEXT_W-1:0]      emit_ext;
    logic                   restart_now;

    assign restart_now = cmd.start && restart;

    // next wheel candidate, carry out means overflow
    assign cand_sum = {1'b0, cand_reg}
                    + (phase_reg ? (PRIME_WIDTH+1)'(4) : (PRIME_WIDTH+1)'(2));

    // sequence registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= LIMIT_W'(LIMIT_RESET);
            found_reg   <= CNT_W'(2);
            emitted_reg <= '0;
            idx_reg     <= '0;
            cand_reg    <= PRIME_WIDTH'(5);
            phase_reg   <= 1'b0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            if (restart_now)
            begin
                found_reg   <= CNT_W'(2);
                emitted_reg <= '0;
                idx_reg     <= '0;
                cand_reg    <= PRIME_WIDTH'(5);
                phase_reg   <= 1'b0;
                ovf_reg     <= 1'b0;
            end
            else
            begin
                if (cmd.clr_idx)
                begin
                    idx_reg <= '0;
                end
                else if (cmd.inc_idx)
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
                if (cmd.commit)
                begin
                    found_reg <= found_reg + CNT_W'(1);
                end
                if (cmd.commit || cmd.emit_table)
                begin
                    emitted_reg <= emitted_reg + CNT_W'(1);
                end
                if (cmd.advance || cmd.commit)
                begin
                    if (cand_sum[PRIME_WIDTH])
                    begin
                        ovf_reg <= 1'b1;
                    end
                    else
                    begin
                        cand_reg  <= cand_sum[PRIME_WIDTH-1:0];
                        phase_reg <= ~phase_reg;
                    end
                end
            end
        end
    end

    // table: entries 0 and 1 are the fixed primes 2 and 3
    assign rd_en        = cmd.rd_emit || cmd.rd_div;
    assign rd_addr_full = cmd.rd_emit ? emitted_reg : idx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            mem[found_reg[AW-1:0]] <= cand_reg;
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr_full[AW-1:0]];
            rd_two_reg   <= (rd_addr_full == CNT_W'(0));
            rd_three_reg <= (rd_addr_full == CNT_W'(1));
        end
    end

    assign p_val = rd_two_reg   ? PRIME_WIDTH'(2) :
                   rd_three_reg ? PRIME_WIDTH'(3) : rd_data_reg;

    // restoring divider step, one quotient bit per cycle
    assign trial    = {rem_reg, quo_reg[PRIME_WIDTH-1]};
    assign diff     = trial - {1'b0, dvs_reg};
    assign trial_ge = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
        end
        else if (cmd.div_load)
        begin
            dcnt_reg <= DCNT_W'(PRIME_WIDTH);
        end
        else if (cmd.div_step)
        begin
            dcnt_reg <= dcnt_reg - DCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            dvs_reg <= p_val;
            quo_reg <= cand_reg;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? diff[PRIME_WIDTH-1:0] : trial[PRIME_WIDTH-1:0];
            quo_reg <= {quo_reg[PRIME_WIDTH-2:0], trial_ge};
        end
    end

    // result register
    assign cand_ext = EXT_W'(cand_reg);
    assign p_ext    = EXT_W'(p_val);
    assign emit_ext = IEXT_W'(emitted_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit || cmd.emit_table || cmd.emit_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            prime_reg <= cand_ext[PRIME_OUT_W-1:0];
            index_reg <= emit_ext[INDEX_W-1:0];
            done_reg  <= 1'b0;
        end
        else if (cmd.emit_table)
        begin
            prime_reg <= p_ext[PRIME_OUT_W-1:0];
            index_reg <= emit_ext[INDEX_W-1:0];
            done_reg  <= 1'b0;
        end
        else if (cmd.emit_done)
        begin
            prime_reg <= '0;
            index_reg <= '0;
            done_reg  <= 1'b1;
        end
    end

    assign out_valid   = out_valid_reg;
    assign prime       = prime_reg;
    assign prime_index = index_reg;
    assign done_res    = done_reg;

    // status toward the controller
    always_comb
    begin
        status.at_limit = (CMP_W'(emitted_reg) >= CMP_W'(limit_reg))
                       || (CMP_W'(emitted_reg) >= CMP_W'(TABLE_DEPTH));
        status.need_new = (emitted_reg >= found_reg);
        status.stop     = ovf_reg || (found_reg >= CNT_W'(TABLE_DEPTH));
        status.idx_end  = (idx_reg >= found_reg);
        status.div_last = (dcnt_reg == DCNT_W'(1));
        status.p_gt_q   = (dvs_reg > quo_reg);
        status.rem_zero = (rem_reg == '0);
        status.out_free = !out_valid_reg || out_ready;
    end

endmodule

// File: rtl/core/psg_ctrl.sv
module psg_ctrl
    import psg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  psg_status_t status,
    output psg_cmd_t    cmd
);

    psg_state_t state_reg;
    psg_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.at_limit)
                begin
                    state_next = ST_DONE;
                end
                else if (!status.need_new)
                begin
                    cmd.rd_emit = 1'b1;
                    state_next  = ST_EMIT;
                end
                else if (status.stop)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.clr_idx = 1'b1;
                    state_next  = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                if (status.idx_end)
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    cmd.rd_div = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                // divisor above the quotient: no factor left, candidate is prime
                if (status.p_gt_q)
                begin
                    state_next = ST_COMMIT;
                end
                else if (status.rem_zero)
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_CHECK;
                end
                else
                begin
                    cmd.inc_idx = 1'b1;
                    state_next  = ST_FETCH;
                end
            end
            ST_COMMIT:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_table = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.emit_done = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/prime_sequence_generator.sv
// channel   | handshake            | payload
// ----------+----------------------+----------------------------------
// request   | in_valid / in_ready  | restart
// result    | out_valid / out_ready| prime, prime_index, done_res
// config    | cfg_wr_en            | cfg_wr_data (prime_limit)
//
// one request at a time; a table hit goes through CHECK and EMIT, a done answer
// through CHECK and DONE; a new prime tries each stored divisor in turn through
// FETCH, LOAD, DIV and EVAL, the DIV state running the one-bit-per-cycle
// restoring divider; a candidate left with no factor is then committed
// rst_n clears the sequence to 2, 3, 5 and sets prime_limit to 4096
// the result register frees the request side; a stalled result only holds
// up the next request once it is ready to deliver
module prime_sequence_generator
    import psg_pkg::*;
#(
    parameter int TABLE_DEPTH = 4096,
    parameter int PRIME_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [LIMIT_W-1:0]     cfg_wr_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   restart,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [PRIME_OUT_W-1:0] prime,
    output logic [INDEX_W-1:0]     prime_index,
    output logic                   done_res
);

    psg_cmd_t    cmd;
    psg_status_t status;

    // sequencing
    psg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // table, candidate, divider and result register
    psg_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .PRIME_WIDTH (PRIME_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .restart     (restart),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .prime       (prime),
        .prime_index (prime_index),
        .done_res    (done_res)
    );

endmodule

// File: rtl/core/psg_checker.sv
`include "assert_macros.svh"

module psg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] prime,
    input logic [12:0] prime_index,
    input logic        done_res
);

    // a done answer carries no prime
    `PSG_ASSERT_IMP(a_done_zero, clk, rst_n, out_valid && done_res, (prime == 32'd0) && (prime_index == 13'd0), "done result with nonzero fields")

    // a real prime is never zero
    `PSG_ASSERT_IMP(a_prime_nonzero, clk, rst_n, out_valid && !done_res, prime != 32'd0, "prime result is zero")

    // one request in flight at a time
    `PSG_ASSERT_NXT(a_busy_after_req, clk, rst_n, in_valid && in_ready, !in_ready, "request taken while busy")

    // stalled result holds
    `PSG_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(prime) && $stable(prime_index) && $stable(done_res), "stalled result changed")

endmodule

bind prime_sequence_generator psg_checker u_psg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .prime       (prime),
    .prime_index (prime_index),
    .done_res    (done_res)
);

// File: dv/tb_prime_sequence_generator.sv
`timescale 1ns / 100ps

module tb_prime_sequence_generator;
    import psg_pkg::*;

    localparam int TBL_DEPTH    = 4096;
    localparam int MAX_CYCLES   = 20_000_000;
    localparam int DRAIN_CYCLES = 50;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 215;
    localparam int LIMIT_MAX    = (1 << LIMIT_W) - 1;

    // one request as queued for the driver, with the idle gap that follows it
    typedef struct {
        bit restart;
        int gap;
    } prime_req_t;

    typedef struct {
        bit [PRIME_OUT_W-1:0] prime;
        bit [INDEX_W-1:0]     index;
        bit                   done;
    } prime_res_t;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [LIMIT_W-1:0]     cfg_wr_data = '0;
    logic                   in_valid    = 1'b0;
    logic                   restart     = 1'b0;
    logic                   out_ready   = 1'b0;
    logic                   in_ready;
    logic                   out_valid;
    logic [PRIME_OUT_W-1:0] prime;
    logic [INDEX_W-1:0]     prime_index;
    logic                   done_res;

    prime_req_t request_q[$];
    prime_res_t expected_primes[$];

    // generator state mirrored by the predictor
    bit [PRIME_OUT_W-1:0] prime_tbl [TBL_DEPTH];
    int unsigned          found_cnt;
    int unsigned          emitted_cnt;
    longint unsigned      cand_val;
    bit                   wheel_odd;
    bit                   cand_exhausted;
    bit [LIMIT_W-1:0]     limit_reg = LIMIT_W'(LIMIT_RESET);

    // run bookkeeping
    int  gap_left;
    int  stall_left;
    int  rx_run;
    bit  rx_steady;
    int  hold_left;
    bit  hold_off;
    bit  hold_used;
    bit  pressure_arm;
    int  err_cnt;
    int  reqs_queued;
    int  reqs_sent;
    int  restarts_sent;
    int  results_seen;
    int  done_seen;
    int  limits_tried;
    longint unsigned max_prime_seen;
    longint unsigned cycle_cnt;

    prime_sequence_generator #(
        .TABLE_DEPTH (TBL_DEPTH),
        .PRIME_WIDTH (32)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .prime       (prime),
        .prime_index (prime_index),
        .done_res    (done_res)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // sequence back to 2, 3, 5; table contents and limit are kept
    function automatic void restart_generator();
        prime_tbl[0]   = 2;
        prime_tbl[1]   = 3;
        found_cnt      = 2;
        emitted_cnt    = 0;
        cand_val       = 5;
        wheel_odd      = 1'b0;
        cand_exhausted = 1'b0;
    endfunction

    // true when no stored prime up to the square root divides n
    function automatic bit trial_divide(longint unsigned n);
        longint unsigned p;
        for (int i = 0; i < found_cnt; i++)
        begin
            p = 64'(prime_tbl[i]);
            if (p < 2 || p > n / p)
                return 1'b1;
            if (n % p == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // 6k-1 / 6k+1 wheel: alternately +2 and +4, flag when it would wrap
    function automatic void step_wheel();
        longint unsigned step;
        step = wheel_odd ? 4 : 2;
        if (cand_val > 64'hFFFF_FFFF - step)
            cand_exhausted = 1'b1;
        else
        begin
            cand_val  = cand_val + step;
            wheel_odd = ~wheel_odd;
        end
    endfunction

    // expected answer to one request, advancing the mirrored state
    function automatic prime_res_t predict_next_prime(bit rs);
        prime_res_t  r;
        int unsigned lim;
        bit          got;
        lim = (32'(limit_reg) > TBL_DEPTH) ? TBL_DEPTH : 32'(limit_reg);
        if (rs)
            restart_generator();
        r.prime = '0;
        r.index = '0;
        r.done  = 1'b1;
        if (emitted_cnt >= lim)
            return r;
        if (emitted_cnt >= found_cnt)
        begin
            got = 1'b0;
            while (!got)
            begin
                if (cand_exhausted || found_cnt >= TBL_DEPTH)
                    return r;
                if (trial_divide(cand_val))
                begin
                    prime_tbl[found_cnt] = cand_val[PRIME_OUT_W-1:0];
                    found_cnt++;
                    got = 1'b1;
                end
                step_wheel();
            end
        end
        r.prime = prime_tbl[emitted_cnt];
        r.index = emitted_cnt[INDEX_W-1:0];
        r.done  = 1'b0;
        emitted_cnt++;
        return r;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        prime_req_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            restart  <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_primes.push_back(predict_next_prime(restart));
                reqs_sent++;
                if (restart)
                    restarts_sent++;
            end
            if (!(in_valid && !in_ready))
            begin
                if (gap_left > 0)
                begin
                    in_valid <= 1'b0;
                    gap_left--;
                end
                else if (request_q.size() > 0)
                begin
                    nxt = request_q.pop_front();
                    in_valid <= 1'b1;
                    restart  <= nxt.restart;
                    gap_left = nxt.gap;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor and checker, also paces out_ready
    always @(posedge clk or negedge rst_n)
    begin
        prime_res_t exp_r;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
            rx_run     = 0;
            rx_steady  = 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_primes.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected result: prime %0d index %0d done %0b",
                                 prime, prime_index, done_res);
                end
                else
                begin
                    exp_r = expected_primes.pop_front();
                    if (prime !== exp_r.prime || prime_index !== exp_r.index ||
                        done_res !== exp_r.done)
                    begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("mismatch: prime %0d/%0d index %0d/%0d done %0b/%0b (exp/act)",
                                     exp_r.prime, prime, exp_r.index, prime_index,
                                     exp_r.done, done_res);
                    end
                    if (exp_r.done)
                        done_seen++;
                    else if (64'(exp_r.prime) > max_prime_seen)
                        max_prime_seen = 64'(exp_r.prime);
                end
                // stretches of steady draining mixed with random stalls
                if (rx_run == 0)
                begin
                    rx_run    = $urandom_range(20, 60);
                    rx_steady = ($urandom_range(0, 2) == 0);
                end
                rx_run--;
                stall_left = rx_steady ? 0 : $urandom_range(0, 9);
            end
            if (hold_off)
                out_ready <= 1'b0;
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // one long receiver hold-off so the block backs up into the request side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_off  <= 1'b0;
            hold_left <= 0;
            hold_used <= 1'b0;
        end
        else if (pressure_arm && !hold_used)
        begin
            hold_off  <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            if (hold_left == 1)
                hold_off <= 1'b0;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= 64'(MAX_CYCLES))
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic push_request(bit rs, bit steady);
        request_q.push_back('{restart: rs, gap: steady ? 0 : $urandom_range(0, 9)});
        reqs_queued++;
    endtask

    // block is idle once every request went out and every result came back
    task automatic wait_idle();
        do
            @(negedge clk);
        while (request_q.size() != 0 || in_valid || expected_primes.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_prime_limit(int unsigned v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v[LIMIT_W-1:0];
        limit_reg   = v[LIMIT_W-1:0];
        limits_tried++;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // mostly restart-then-run sequences, some random restart noise
    task automatic fill_phase(int n);
        int  first;
        int  len;
        bit  steady;
        first = reqs_queued;
        while (reqs_queued - first < n)
        begin
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                len = $urandom_range(1, 8);
                repeat (len) push_request($urandom_range(0, 1), steady);
            end
            else
            begin
                len = ($urandom_range(0, 14) == 0) ? $urandom_range(60, 250)
                                                   : $urandom_range(0, 30);
                // first run of a phase may continue the old sequence
                if (reqs_queued != first || $urandom_range(0, 1))
                    push_request(1'b1, steady);
                repeat (len) push_request(1'b0, steady);
            end
        end
    endtask

    initial
    begin
        int unsigned phase_limit [6];
        restart_generator();
        phase_limit[0] = LIMIT_RESET;
        phase_limit[1] = $urandom_range(2, 60);
        phase_limit[2] = LIMIT_MAX;
        phase_limit[3] = $urandom_range(0, 12);
        phase_limit[4] = $urandom_range(13, 600);
        phase_limit[5] = LIMIT_RESET;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset limit: first primes, composite 25 on the wheel, restarts
        repeat (10) push_request(1'b0, 1'b0);
        push_request(1'b1, 1'b0);
        push_request(1'b1, 1'b1);
        push_request(1'b0, 1'b1);
        push_request(1'b0, 1'b0);

        // limit zero answers done even right after a restart
        wait_idle();
        write_prime_limit(0);
        push_request(1'b1, 1'b0);
        push_request(1'b0, 1'b0);

        // limit one: a single prime then done
        wait_idle();
        write_prime_limit(1);
        push_request(1'b1, 1'b0);
        push_request(1'b0, 1'b0);
        push_request(1'b0, 1'b1);

        // limit two: served from the preset table entries only
        wait_idle();
        write_prime_limit(2);
        push_request(1'b1, 1'b0);
        repeat (3) push_request(1'b0, 1'b0);

        // limit above table depth clamps to the depth
        wait_idle();
        write_prime_limit(LIMIT_MAX);
        push_request(1'b1, 1'b0);
        push_request(1'b0, 1'b0);

        // random phases under several limits
        for (int ph = 0; ph < 6; ph++)
        begin
            wait_idle();
            write_prime_limit(phase_limit[ph]);
            fill_phase(PHASE_ITEMS);
            if (ph == 0)
                pressure_arm = 1'b1;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_primes.size() != 0)
            err_cnt++;

        $display("covered %0d requests (%0d restarts) under %0d limit settings, %0d results",
                 reqs_sent, restarts_sent, limits_tried, results_seen);
        $display("%0d done answers, largest prime returned %0d, %0d errors",
                 done_seen, max_prime_seen, err_cnt);
        if (err_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/psg_pkg.sv
rtl/core/psg_datapath.sv
rtl/core/psg_ctrl.sv
rtl/core/prime_sequence_generator.sv
rtl/core/psg_checker.sv
dv/tb_prime_sequence_generator.sv
